>>> rtl/core/tasi_pkg.sv
// Shared types and constants of the three-axis step interpolator.
package tasi_pkg;

  localparam int NUM_AXES  = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] PULSE_TICKS_RST  = 8'd5;
  localparam logic [CFG_W-1:0] SETTLE_TICKS_RST = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_STOP = 2'd2,
    CMD_HOME = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_TICKS  = 1'b0,
    REG_SETTLE_TICKS = 1'b1
  } cfg_reg_t;

  // Per-axis strobes issued by the sequencer for one accepted word.
  typedef struct packed {
    logic latch;    // load a new move count
    logic clear;    // zero accumulator and pulse hold
    logic iterate;  // run one interpolation iteration
    logic commit;   // add the count to the position
    logic home;     // zero the position
  } axis_ctl_t;

  // Sequencer status after the word, registered with the result.
  typedef struct packed {
    logic busy;
    logic pulse_win;
    logic accepted;
  } ctrl_stat_t;

endpackage

>>> rtl/core/tasi_axis.sv
// One axis: count latch, DDA accumulator, pulse hold and position.
module tasi_axis
  import tasi_pkg::*;
#(
  parameter int DELTA_WIDTH = 24,
  parameter int POS_WIDTH   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  axis_ctl_t              ctl,
  input  logic [DELTA_WIDTH-1:0] in_delta,
  input  logic [DELTA_WIDTH-1:0] largest,
  output logic [DELTA_WIDTH-1:0] in_mag,
  output logic                   dir_nxt,
  output logic                   hold_nxt,
  output logic [POS_WIDTH-1:0]   pos_nxt
);

  localparam int EXT_W = (POS_WIDTH > DELTA_WIDTH) ? POS_WIDTH : DELTA_WIDTH;

  logic [DELTA_WIDTH-1:0] delta_r, delta_nxt;
  logic [DELTA_WIDTH-1:0] acc_r, acc_nxt;
  logic                   hold_r;
  logic [POS_WIDTH-1:0]   pos_r;
  logic [DELTA_WIDTH-1:0] mag;
  logic [DELTA_WIDTH:0]   sum;
  logic signed [EXT_W-1:0] delta_ext;

  // Two's complement magnitude; the most negative count maps to 2^(W-1).
  assign in_mag = in_delta[DELTA_WIDTH-1] ? (~in_delta + 1'b1) : in_delta;
  assign mag    = delta_r[DELTA_WIDTH-1] ? (~delta_r + 1'b1) : delta_r;
  assign sum    = {1'b0, acc_r} + {1'b0, mag};
  assign delta_ext = EXT_W'($signed(delta_r));

  always_comb begin
    delta_nxt = ctl.latch ? in_delta : delta_r;
    acc_nxt   = acc_r;
    hold_nxt  = hold_r;
    pos_nxt   = pos_r;
    if (ctl.clear) begin
      acc_nxt  = '0;
      hold_nxt = 1'b0;
    end else if (ctl.iterate) begin
      if (sum >= {1'b0, largest}) begin
        acc_nxt  = DELTA_WIDTH'(sum - {1'b0, largest});
        hold_nxt = 1'b1;
      end else begin
        acc_nxt  = DELTA_WIDTH'(sum);
        hold_nxt = 1'b0;
      end
    end
    if (ctl.home) begin
      pos_nxt = '0;
    end else if (ctl.commit) begin
      pos_nxt = pos_r + delta_ext[POS_WIDTH-1:0];
    end
  end

  assign dir_nxt = ~delta_nxt[DELTA_WIDTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= '0;
      acc_r   <= '0;
      hold_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      delta_r <= delta_nxt;
      acc_r   <= acc_nxt;
      hold_r  <= hold_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

>>> rtl/core/tasi_ctrl.sv
// Move sequencer: phase, a shared settle/period tick counter, iteration count.
module tasi_ctrl
  import tasi_pkg::*;
#(
  parameter int DELTA_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  cmd_t                                  cmd,
  input  logic [NUM_AXES-1:0][DELTA_WIDTH-1:0]  mags,
  input  logic [PERIOD_WIDTH-1:0]               in_period,
  input  logic [CFG_W-1:0]                      pulse_ticks,
  input  logic [CFG_W-1:0]                      settle_ticks,
  output axis_ctl_t                             ctl,
  output logic [DELTA_WIDTH-1:0]                largest,
  output ctrl_stat_t                            stat
);

  // The raised period can reach 2^CFG_W, so the tick counter is at least CFG_W+1 wide.
  localparam int TW = (PERIOD_WIDTH > CFG_W + 1) ? PERIOD_WIDTH : CFG_W + 1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SETTLE = 3'b010,
    PH_RUN    = 3'b100
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [TW-1:0]          tick_r, tick_nxt;
  logic [TW-1:0]          period_r, period_nxt;
  logic [DELTA_WIDTH-1:0] iter_r, iter_nxt;
  logic [DELTA_WIDTH-1:0] largest_r, largest_nxt;
  logic [DELTA_WIDTH-1:0] big;
  logic [TW-1:0]          period_min, period_in;
  logic                   do_iter;

  always_comb begin
    big = mags[0];
    for (int k = 1; k < NUM_AXES; k++) begin
      if (mags[k] > big) big = mags[k];
    end
  end

  assign period_min = TW'(pulse_ticks) + 1'b1;
  assign period_in  = TW'(in_period);

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    period_nxt   = period_r;
    iter_nxt     = iter_r;
    largest_nxt  = largest_r;
    ctl          = '0;
    stat         = '0;
    do_iter      = 1'b0;
    if (fire) begin
      unique case (cmd)
        CMD_MOVE: begin
          if (phase_r == PH_IDLE) begin
            ctl.latch = 1'b1;
            if (big != '0) begin
              largest_nxt   = big;
              iter_nxt      = big;
              period_nxt    = (period_in < period_min) ? period_min : period_in;
              ctl.clear     = 1'b1;
              tick_nxt      = TW'(settle_ticks);
              phase_nxt     = PH_SETTLE;
              stat.accepted = 1'b1;
            end
          end
        end
        CMD_STOP: begin
          if (phase_r != PH_IDLE) begin
            ctl.clear = 1'b1;
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
            iter_nxt  = '0;
          end
        end
        CMD_HOME: begin
          ctl.home      = 1'b1;
          stat.accepted = 1'b1;
        end
        CMD_TICK: begin
          unique case (phase_r)
            PH_SETTLE: begin
              if (tick_r == '0) do_iter = 1'b1;
              else tick_nxt = tick_r - 1'b1;
            end
            PH_RUN: begin
              if (tick_r >= period_r) begin
                if (iter_r == '0) begin
                  ctl.commit = 1'b1;
                  ctl.clear  = 1'b1;
                  phase_nxt  = PH_IDLE;
                  tick_nxt   = '0;
                  iter_nxt   = '0;
                end else begin
                  do_iter = 1'b1;
                end
              end else begin
                tick_nxt = tick_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      endcase
    end
    if (do_iter) begin
      ctl.iterate = 1'b1;
      phase_nxt   = PH_RUN;
      tick_nxt    = TW'(1);
      if (iter_r != '0) iter_nxt = iter_r - 1'b1;
    end
    stat.busy      = (phase_nxt != PH_IDLE);
    stat.pulse_win = (phase_nxt == PH_RUN) && (tick_nxt <= TW'(pulse_ticks));
  end

  assign largest = largest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      period_r  <= '0;
      iter_r    <= '0;
      largest_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      period_r  <= period_nxt;
      iter_r    <= iter_nxt;
      largest_r <= largest_nxt;
    end
  end

endmodule

>>> rtl/core/three_axis_step_interpolator.sv
// Three-axis step interpolator: stream channels, config registers, result register.
//
// Usage:
//   Input words (in_*) carry a command in in_tuser (tick, move, stop, home)
//   and the move operands in in_tdata. Only tick words advance time: drive
//   one tick word per timebase tick. Every accepted word yields exactly one
//   result word (out_*) with step levels, directions, enable, busy, the
//   accepted flag and the three completed positions.
//   The result of a word accepted at a clock edge is registered and presented
//   from the next cycle. Throughput is one word per cycle while the receiver
//   takes each result, as the state update feeds the result register directly.
//   When the receiver stalls, the result word holds and in_tready drops
//   until it is taken; a new word is accepted in the same cycle the pending
//   result is taken.
//   Configuration writes (cfg_*) are always ready: index 0 pulse_ticks,
//   index 1 settle_ticks. Write them only while no move is running.
//   Reset (rst_n low, synchronous) returns the block to idle with zero
//   positions, all directions positive, pulse 5 ticks and settle 10 ticks.
module three_axis_step_interpolator
  import tasi_pkg::*;
#(
  parameter int POS_WIDTH    = 32,
  parameter int DELTA_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // in_tdata, low bit up: move_a, move_b, move_c, period_ticks, zero fill
  input  logic [((3*DELTA_WIDTH+PERIOD_WIDTH+7)/8)*8-1:0] in_tdata,
  // in_tuser, low bit up: cmd
  input  logic [CMD_W-1:0]        in_tuser,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // out_tdata, low bit up: pulse_a, pulse_b, pulse_c, dir_a, dir_b, dir_c,
  // drive_enable, busy_res, accepted, pos_a, pos_b, pos_c, zero fill
  output logic [((9+3*POS_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int OUT_B  = 9 + 3*POS_WIDTH;
  localparam int OUT_W  = ((OUT_B + 7) / 8) * 8;
  localparam int PER_LO = 3*DELTA_WIDTH;

  logic                                 in_fire;
  logic                                 out_tvalid_r;
  logic [OUT_W-1:0]                     out_tdata_r;
  logic [CFG_W-1:0]                     pulse_ticks_r;
  logic [CFG_W-1:0]                     settle_ticks_r;
  axis_ctl_t                            ctl;
  ctrl_stat_t                           stat;
  logic [DELTA_WIDTH-1:0]               largest;
  logic [NUM_AXES-1:0][DELTA_WIDTH-1:0] mags;
  logic [NUM_AXES-1:0]                  dir_nxt;
  logic [NUM_AXES-1:0]                  hold_nxt;
  logic [NUM_AXES-1:0][POS_WIDTH-1:0]   pos_nxt;
  logic [OUT_B-1:0]                     result;

  // Accept whenever the result register is free or being emptied.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Hold the two timing registers; write them only while idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r  <= PULSE_TICKS_RST;
      settle_ticks_r <= SETTLE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PULSE_TICKS) pulse_ticks_r <= cfg_data;
      else settle_ticks_r <= cfg_data;
    end
  end

  tasi_ctrl #(
    .DELTA_WIDTH  (DELTA_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .cmd          (cmd_t'(in_tuser)),
    .mags         (mags),
    .in_period    (in_tdata[PER_LO +: PERIOD_WIDTH]),
    .pulse_ticks  (pulse_ticks_r),
    .settle_ticks (settle_ticks_r),
    .ctl          (ctl),
    .largest      (largest),
    .stat         (stat)
  );

  // One DDA lane per axis; all lanes share the sequencer strobes.
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    tasi_axis #(
      .DELTA_WIDTH (DELTA_WIDTH),
      .POS_WIDTH   (POS_WIDTH)
    ) u_axis (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .in_delta (in_tdata[k*DELTA_WIDTH +: DELTA_WIDTH]),
      .largest  (largest),
      .in_mag   (mags[k]),
      .dir_nxt  (dir_nxt[k]),
      .hold_nxt (hold_nxt[k]),
      .pos_nxt  (pos_nxt[k])
    );
  end

  // Pack the post-word state; a step level shows only inside the pulse window.
  assign result = {pos_nxt[2], pos_nxt[1], pos_nxt[0], stat.accepted, stat.busy,
                   stat.busy, dir_nxt, hold_nxt & {NUM_AXES{stat.pulse_win}}};

  // Load the result on accept, drop valid once the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_tdata_r <= OUT_W'(result);
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // An accepted word always leaves a result waiting in the next cycle.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid_r)
    else $error("accepted word produced no result");

  // A visible step pulse only occurs while the move is busy and enabled.
  a_pulse_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tdata_r[2:0] != 3'b000)) |-> (out_tdata_r[7] && out_tdata_r[6]))
    else $error("step pulse outside a move");

  // Iteration and clearing of the lanes never coincide.
  a_iter_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.iterate && ctl.clear))
    else $error("iterate and clear strobes together");
`endif

endmodule

>>> test/three_axis_step_interpolator_tb.sv
// Self-checking testbench of the three-axis step interpolator: directed and random words.
module three_axis_step_interpolator_tb;
  import tasi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W        = 88;   // move_a, move_b, move_c, period_ticks
  localparam int OUT_W       = 112;  // 105 result bits plus zero fill
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off for the pressure test
  localparam int DRAIN_GUARD = 20000;

  // Motion phase of the predictor.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_RUN
  } motion_phase_t;

  // One result word, split into its fields; pos[0] is axis a.
  typedef struct packed {
    logic [2:0]       step;
    logic [2:0]       dir;
    logic             enable;
    logic             busy;
    logic             taken;
    logic [2:0][31:0] pos;
  } motion_word_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic [IN_W-1:0]  in_tdata;
  logic [CMD_W-1:0] in_tuser;
  logic             in_tvalid;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Predictor state: registers and the motion sequencer.
  logic [7:0]    pulse_len;
  logic [7:0]    settle_len;
  logic [31:0]   pos_now [3];
  logic [23:0]   move_cnt [3];
  logic [24:0]   acc [3];
  logic [23:0]   span;        // largest magnitude of the running move
  logic [23:0]   iters_left;  // iterations still to start
  logic [16:0]   tick_cnt;
  logic [16:0]   period_now;
  motion_phase_t phase_now;
  logic [2:0]    step_mask;

  motion_word_t motion_expect[$];
  int           mismatches   = 0;
  int           results_seen = 0;
  bit           no_idle      = 1'b0;  // suppress random gaps on both sides
  int           hold_order   = 0;     // bumped to request one long receiver hold

  always #5 clk = ~clk;

  three_axis_step_interpolator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Magnitude of a signed count; the most negative count gives 2^23.
  function automatic logic [23:0] step_magnitude(logic [23:0] cnt);
    logic [24:0] wide;
    wide = {cnt[23], cnt};
    if (cnt[23]) begin
      wide = -wide;
    end
    return wide[23:0];
  endfunction

  // One interpolation iteration: every axis adds its magnitude and steps on overflow.
  function automatic void start_iteration();
    int k;
    phase_now = PH_RUN;
    if (iters_left != 0) begin
      iters_left = iters_left - 24'd1;
    end
    step_mask = 3'b000;
    for (k = 0; k < 3; k++) begin
      acc[k] = acc[k] + {1'b0, step_magnitude(move_cnt[k])};
      if (acc[k] >= {1'b0, span}) begin
        step_mask[k] = 1'b1;
        acc[k]       = acc[k] - {1'b0, span};
      end
    end
    tick_cnt = 17'd1;
  endfunction

  // Drop back to idle; latched counts and positions stay.
  function automatic void halt_motion();
    int k;
    phase_now  = PH_IDLE;
    step_mask  = 3'b000;
    tick_cnt   = '0;
    iters_left = '0;
    for (k = 0; k < 3; k++) begin
      acc[k] = '0;
    end
  endfunction

  // Apply one accepted word to the predictor and return the result it yields.
  function automatic motion_word_t advance_motion(cmd_t cmd, logic [23:0] cnt_a,
                                                  logic [23:0] cnt_b, logic [23:0] cnt_c,
                                                  logic [15:0] per);
    motion_word_t w;
    logic [23:0]  cnt [3];
    logic [23:0]  big;
    logic [23:0]  mag;
    logic [16:0]  per_eff;
    logic         taken;
    int           k;
    cnt[0] = cnt_a;
    cnt[1] = cnt_b;
    cnt[2] = cnt_c;
    taken  = 1'b0;
    case (cmd)
      CMD_MOVE: begin
        // Ignored while busy; an all-zero move only latches the counts.
        if (phase_now == PH_IDLE) begin
          big = '0;
          for (k = 0; k < 3; k++) begin
            move_cnt[k] = cnt[k];
            mag = step_magnitude(cnt[k]);
            if (mag > big) begin
              big = mag;
            end
          end
          if (big != 0) begin
            per_eff = {1'b0, per};
            if (per_eff < {9'd0, pulse_len} + 17'd1) begin
              per_eff = {9'd0, pulse_len} + 17'd1;
            end
            span       = big;
            iters_left = big;
            period_now = per_eff;
            for (k = 0; k < 3; k++) begin
              acc[k] = '0;
            end
            step_mask = 3'b000;
            tick_cnt  = {9'd0, settle_len};
            phase_now = PH_SETTLE;
            taken     = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        if (phase_now != PH_IDLE) begin
          halt_motion();
        end
      end
      CMD_HOME: begin
        for (k = 0; k < 3; k++) begin
          pos_now[k] = '0;
        end
        taken = 1'b1;
      end
      default: begin
        if (phase_now == PH_SETTLE) begin
          if (tick_cnt == 0) begin
            start_iteration();
          end else begin
            tick_cnt = tick_cnt - 17'd1;
          end
        end else if (phase_now == PH_RUN) begin
          if (tick_cnt >= period_now) begin
            if (iters_left == 0) begin
              // Move complete: fold the counts into the positions, wrapping.
              for (k = 0; k < 3; k++) begin
                pos_now[k] = pos_now[k] + {{8{move_cnt[k][23]}}, move_cnt[k]};
              end
              halt_motion();
            end else begin
              start_iteration();
            end
          end else begin
            tick_cnt = tick_cnt + 17'd1;
          end
        end
      end
    endcase
    for (k = 0; k < 3; k++) begin
      w.step[k] = (phase_now == PH_RUN) && step_mask[k] && (tick_cnt <= {9'd0, pulse_len});
      w.dir[k]  = ~move_cnt[k][23];
      w.pos[k]  = pos_now[k];
    end
    w.enable = (phase_now != PH_IDLE);
    w.busy   = (phase_now != PH_IDLE);
    w.taken  = taken;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving and checking
  // ---------------------------------------------------------------------------

  function automatic int idle_draw();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    end
  endtask

  // Offer one word after a random gap; predict it once it is taken. Enter and leave
  // at a falling edge. Valid stays high when the next word follows without a gap.
  task automatic send_word(cmd_t cmd, logic [23:0] cnt_a, logic [23:0] cnt_b,
                           logic [23:0] cnt_c, logic [15:0] per);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {per, cnt_c, cnt_b, cnt_a};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    motion_expect.push_back(advance_motion(cmd, cnt_a, cnt_b, cnt_c, per));
    @(negedge clk);
  endtask

  // Tick, stop and home words carry random operand bits, which the block ignores.
  task automatic send_plain(cmd_t cmd);
    send_word(cmd, 24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
  endtask

  // Release the input, wait for every expected result, then let the pipe go quiet.
  task automatic wait_idle();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (motion_expect.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (3) @(negedge clk);
  endtask

  // Write both timing registers back to back; call only with the block idle.
  task automatic load_timing(logic [7:0] pulse, logic [7:0] settle);
    cfg_index <= REG_PULSE_TICKS;
    cfg_data  <= pulse;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pulse_len = pulse;
    @(negedge clk);
    cfg_index <= REG_SETTLE_TICKS;
    cfg_data  <= settle;
    do @(posedge clk); while (!cfg_ready);
    settle_len = settle;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random signed count of bounded magnitude.
  function automatic logic [23:0] short_count(int max_mag);
    int mag;
    mag = $urandom_range(0, max_mag);
    return $urandom_range(0, 1) ? 24'(-mag) : 24'(mag);
  endfunction

  // Well-formed move sequences: a move, then ticks until it ends, with homes,
  // busy moves and early stops mixed in. Wild moves with full-range operands
  // always get stopped early so the run stays short.
  task automatic drive_moves(int budget, int max_mag, int max_period);
    int sent;
    int ticks_done;
    int stop_after;
    int r;
    sent = 0;
    while (sent < budget) begin
      no_idle    = ($urandom_range(0, 3) == 0);
      stop_after = -1;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_word(CMD_MOVE, '0, '0, '0, 16'($urandom));
      end else if (r < 20) begin
        stop_after = $urandom_range(0, 30);
        send_word(CMD_MOVE, 24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          stop_after = $urandom_range(0, 40);
        end
        send_word(CMD_MOVE, short_count(max_mag), short_count(max_mag),
                  short_count(max_mag), 16'($urandom_range(0, max_period)));
      end
      sent++;
      ticks_done = 0;
      while (phase_now != PH_IDLE) begin
        r = $urandom_range(0, 99);
        if (ticks_done == stop_after) begin
          send_plain(CMD_STOP);
        end else if (r < 3) begin
          send_plain(CMD_HOME);
        end else if (r < 6) begin
          send_word(CMD_MOVE, 24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
        end else begin
          send_plain(CMD_TICK);
          ticks_done++;
        end
        sent++;
      end
      // Occasional noise between moves: stray tick, stop or home while idle.
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 2);
        send_plain(r == 0 ? CMD_TICK : (r == 1 ? CMD_STOP : CMD_HOME));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: take words with random stalls, check each against the oldest
  // expectation, and serve long hold-off requests.
  initial begin : result_sink
    motion_word_t got;
    motion_word_t want;
    int           stall;
    int           hold_left;
    int           hold_seen;
    int           k;
    stall      = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.step   = out_tdata[2:0];
        got.dir    = out_tdata[5:3];
        got.enable = out_tdata[6];
        got.busy   = out_tdata[7];
        got.taken  = out_tdata[8];
        got.pos    = out_tdata[104:9];
        if (motion_expect.size() == 0) begin
          report_mismatch("result word with nothing pending", 1, 0);
        end else begin
          want = motion_expect.pop_front();
          for (k = 0; k < 3; k++) begin
            if (got.step[k] != want.step[k]) begin
              report_mismatch($sformatf("pulse of axis %0d", k), got.step[k], want.step[k]);
            end
            if (got.dir[k] != want.dir[k]) begin
              report_mismatch($sformatf("dir of axis %0d", k), got.dir[k], want.dir[k]);
            end
            if (got.pos[k] != want.pos[k]) begin
              report_mismatch($sformatf("pos of axis %0d", k),
                              $signed(got.pos[k]), $signed(want.pos[k]));
            end
          end
          if (got.enable != want.enable) begin
            report_mismatch("drive_enable", got.enable, want.enable);
          end
          if (got.busy != want.busy) begin
            report_mismatch("busy_res", got.busy, want.busy);
          end
          if (got.taken != want.taken) begin
            report_mismatch("accepted", got.taken, want.taken);
          end
        end
        results_seen++;
        stall = idle_draw();
      end
      @(negedge clk);
      if (hold_order != hold_seen) begin
        hold_seen = hold_order;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle behavior at reset settings: tick, stop, home, and an all-zero move.
  task automatic test_idle_commands();
    send_plain(CMD_TICK);
    send_plain(CMD_STOP);
    send_plain(CMD_HOME);
    send_word(CMD_MOVE, '0, '0, '0, 16'd5);
  endtask

  // Extreme counts and period, then a busy move, a home mid-move and an abort.
  task automatic test_abort_extremes();
    wait_idle();
    load_timing(8'd1, 8'd0);
    send_word(CMD_MOVE, 24'h800000, 24'h7FFFFF, 24'h000000, 16'hFFFF);
    send_plain(CMD_TICK);
    send_plain(CMD_TICK);
    send_plain(CMD_TICK);
    send_word(CMD_MOVE, 24'd1, 24'd1, 24'd1, 16'd1);
    send_plain(CMD_HOME);
    send_plain(CMD_STOP);
  endtask

  // A short move with a zero period runs to completion and lands its counts.
  task automatic test_move_completion();
    send_word(CMD_MOVE, 24'd3, -24'sd2, 24'd1, 16'd0);
    while (phase_now != PH_IDLE) begin
      send_plain(CMD_TICK);
    end
    send_plain(CMD_TICK);
  endtask

  // Random move traffic under one pair of timing settings.
  task automatic test_timing(logic [7:0] pulse, logic [7:0] settle, int budget,
                             int max_mag, int max_period);
    wait_idle();
    load_timing(pulse, settle);
    drive_moves(budget, max_mag, max_period);
    send_plain(CMD_STOP);
  endtask

  // Receiver holds off for a long stretch while moves keep coming; the result
  // register fills and the input has to stall.
  task automatic test_output_stall();
    wait_idle();
    load_timing(8'd2, 8'd3);
    hold_order <= hold_order + 1;
    drive_moves(120, 8, 4);
    send_plain(CMD_STOP);
  endtask

  initial begin : stimulus
    int k;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    cfg_valid  = 1'b0;
    cfg_index  = REG_PULSE_TICKS;
    cfg_data   = '0;
    // Predictor comes up in the reset state.
    pulse_len  = PULSE_TICKS_RST;
    settle_len = SETTLE_TICKS_RST;
    for (k = 0; k < 3; k++) begin
      pos_now[k]  = '0;
      move_cnt[k] = '0;
      acc[k]      = '0;
    end
    span       = '0;
    iters_left = '0;
    tick_cnt   = '0;
    period_now = '0;
    phase_now  = PH_IDLE;
    step_mask  = 3'b000;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_commands();
    test_abort_extremes();
    test_move_completion();
    test_timing(8'd5, 8'd10, 120, 12, 8);   // rewrite the reset values
    test_timing(8'd0, 8'd0, 80, 6, 3);      // no visible pulse, periods of one to three ticks
    test_timing(8'd255, 8'd0, 100, 1, 300); // longest pulse
    test_timing(8'd1, 8'd255, 100, 3, 3);   // longest settle
    test_output_stall();

    wait_idle();
    if (motion_expect.size() != 0) begin
      report_mismatch("words left without a result", motion_expect.size(), 0);
    end
    if (mismatches == 0) begin
      $display("** three_axis_step_interpolator: PASSED **");
    end else begin
      $display("** three_axis_step_interpolator: FAILED **");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #5_000_000;
    $display("** three_axis_step_interpolator: FAILED **");
    $finish;
  end

endmodule
